// ----- rtl/core/bsrs_pkg.sv -----
// Shared constants, command codes and word helpers for the bit-vector rank/select block.
`timescale 1ns / 1ps

package bsrs_pkg;

	localparam int UNIVERSE_SIZE_DEF = 1024;
	localparam int WORD_BITS = 32;
	localparam int BIT_POS_W = $clog2(WORD_BITS);
	localparam int ELEM_W = 10;
	localparam int COUNT_W = 11;
	localparam int CMD_W = 3;
	localparam int TOP_MAX = 1023;
	localparam int WORDS_MAX = (TOP_MAX + 1) / WORD_BITS;
	localparam logic [ELEM_W-1:0] TOP_RESET = 10'd1023;

	typedef enum logic [CMD_W-1:0] {
		CMD_CLEAR  = 3'd0,
		CMD_INSERT = 3'd1,
		CMD_DELETE = 3'd2,
		CMD_MEMBER = 3'd3,
		CMD_RANK   = 3'd4,
		CMD_SELECT = 3'd5,
		CMD_RANGE  = 3'd6,
		CMD_NONE   = 3'd7
	} cmd_t;

	// Adder tree over one 32-bit word, one level per loop.
	function automatic logic [BIT_POS_W:0] popcount32(input logic [WORD_BITS-1:0] w);
		logic [1:0] l1 [16];
		logic [2:0] l2 [8];
		logic [3:0] l3 [4];
		logic [4:0] l4 [2];
		for (int i = 0; i < 16; i++) begin
			l1[i] = {1'b0, w[2*i]} + {1'b0, w[2*i+1]};
		end
		for (int i = 0; i < 8; i++) begin
			l2[i] = {1'b0, l1[2*i]} + {1'b0, l1[2*i+1]};
		end
		for (int i = 0; i < 4; i++) begin
			l3[i] = {1'b0, l2[2*i]} + {1'b0, l2[2*i+1]};
		end
		for (int i = 0; i < 2; i++) begin
			l4[i] = {1'b0, l3[2*i]} + {1'b0, l3[2*i+1]};
		end
		return {1'b0, l4[0]} + {1'b0, l4[1]};
	endfunction

endpackage

// ----- rtl/core/bitset_rank_select.sv -----
// Bit-vector set with member count, rank, select and range count.
//
// Usage: commands enter on the in channel (cmd, value, range_end) with in_valid/in_ready;
// each command gives exactly one result on the out channel (answer, is_true,
// out_of_range) with out_valid/out_ready. The top element register is written on the
// cfg channel (cfg_valid/cfg_ready, cfg_data); the user must write it only while no
// command is in flight, as the block itself does not enforce this. The set lives in a
// word memory of 32-bit words, one read port and one write port. Clear, the unused
// command and any command that needs no scan (value above the top, select with a bad
// position, empty range) go from accept straight to the result; insert, delete and
// member first read the word, then modify and write it. Rank, select and range count
// run one shared popcount/accumulate/compare unit over the words of the range, one
// word per cycle behind the registered memory read. Select then walks the hit word one
// bit per cycle. One command is in work at a time; in_ready is low from accept until
// the command's result has been handed to the output register. The output register
// holds a finished result while the receiver stalls; the next command is accepted
// meanwhile and waits at its end until the register frees up. Reset empties the set
// (per-word valid bits clear at once), zeroes the count and sets the top element to
// 1023; the block is ready in the first cycle after reset.
`timescale 1ns / 1ps

module bitset_rank_select #(
	parameter int UNIVERSE_SIZE = bsrs_pkg::UNIVERSE_SIZE_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [bsrs_pkg::ELEM_W-1:0]     cfg_data,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic [bsrs_pkg::CMD_W-1:0]      cmd,
	input  logic [bsrs_pkg::COUNT_W-1:0]    value,
	input  logic [bsrs_pkg::ELEM_W-1:0]     range_end,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [bsrs_pkg::COUNT_W-1:0]    answer,
	output logic                            is_true,
	output logic                            out_of_range
);

	localparam int WB = bsrs_pkg::WORD_BITS;
	localparam int PW = bsrs_pkg::BIT_POS_W;
	localparam int EW = bsrs_pkg::ELEM_W;
	localparam int CW = bsrs_pkg::COUNT_W;
	localparam int TopCapInt = (UNIVERSE_SIZE - 1 > bsrs_pkg::TOP_MAX) ?
		bsrs_pkg::TOP_MAX : UNIVERSE_SIZE - 1;
	localparam logic [EW-1:0] TopCap = EW'(TopCapInt);
	localparam int WordsFull = (UNIVERSE_SIZE + WB - 1) / WB;
	localparam int Words = (WordsFull > bsrs_pkg::WORDS_MAX) ? bsrs_pkg::WORDS_MAX : WordsFull;
	localparam int WAW = (Words > 1) ? $clog2(Words) : 1;

	typedef enum logic [5:0] {
		ST_IDLE   = 6'b000001,
		ST_MODIFY = 6'b000010,
		ST_SCAN   = 6'b000100,
		ST_FIND   = 6'b001000,
		ST_DONE   = 6'b010000,
		ST_SPARE  = 6'b100000
	} state_t;

	state_t state_q;

	logic [EW-1:0]          top_q;
	bsrs_pkg::cmd_t         cmd_q;
	logic [CW-1:0]          val_q;
	logic [EW-1:0]          lo_q;
	logic [EW-1:0]          hi_q;
	logic [CW-1:0]          acc_q;
	logic [CW-1:0]          cnt_q;
	logic [WAW-1:0]         issue_w_q;
	logic [WAW-1:0]         proc_w_q;
	logic                   issue_done_q;
	logic                   dvld_q;
	logic [WB-1:0]          rdata_q;
	logic                   rvld_q;
	logic [WB-1:0]          find_word_q;
	logic [WAW-1:0]         find_w_q;
	logic [PW-1:0]          find_pos_q;
	logic [PW:0]            need_q;
	logic [CW-1:0]          res_answer_q;
	logic                   res_true_q;
	logic                   res_oor_q;
	logic [CW-1:0]          answer_q;
	logic                   is_true_q;
	logic                   oor_q;
	logic                   out_valid_q;
	logic [Words-1:0]       word_vld_q;

	logic [WB-1:0]          mem [Words];

	bsrs_pkg::cmd_t         cmd_in;
	logic                   accept;
	logic [EW-1:0]          eff_top;
	logic                   above;
	logic [EW-1:0]          rend_clip;
	logic                   rd_en;
	logic [WAW-1:0]         rd_addr;
	logic                   wr_en;
	logic [WAW-1:0]         wr_addr;
	logic [WB-1:0]          wr_data;
	logic [WB-1:0]          cur_word;
	logic                   cur_bit;
	logic [CW-1:0]          cnt_mod;
	logic [WAW-1:0]         lo_w;
	logic [WAW-1:0]         hi_w;
	logic [WB-1:0]          lo_mask;
	logic [WB-1:0]          hi_mask;
	logic [WB-1:0]          masked;
	logic [PW:0]            pc;
	logic [CW-1:0]          sum;
	logic                   out_free;

	assign cmd_in    = bsrs_pkg::cmd_t'(cmd);
	assign in_ready  = (state_q == ST_IDLE);
	assign cfg_ready = 1'b1;
	assign accept    = in_valid && in_ready;
	assign eff_top   = (top_q > TopCap) ? TopCap : top_q;
	assign above     = value > {1'b0, eff_top};
	assign rend_clip = (range_end > eff_top) ? eff_top : range_end;
	assign out_free  = !out_valid_q || out_ready;

	assign cur_word = rvld_q ? rdata_q : '0;
	assign cur_bit  = cur_word[val_q[PW-1:0]];
	assign wr_addr  = val_q[WAW+PW-1:PW];
	assign wr_data  = cur_word ^ (WB'(1) << val_q[PW-1:0]);
	assign wr_en    = (state_q == ST_MODIFY) &&
		((cmd_q == bsrs_pkg::CMD_INSERT && !cur_bit) ||
		 (cmd_q == bsrs_pkg::CMD_DELETE && cur_bit));

	always_comb begin
		cnt_mod = cnt_q;
		if (wr_en && cmd_q == bsrs_pkg::CMD_INSERT) begin
			cnt_mod = cnt_q + CW'(1);
		end else if (wr_en) begin
			cnt_mod = cnt_q - CW'(1);
		end
	end

	always_comb begin
		rd_en   = 1'b0;
		rd_addr = issue_w_q;
		if (accept && !above && (cmd_in == bsrs_pkg::CMD_INSERT ||
			cmd_in == bsrs_pkg::CMD_DELETE || cmd_in == bsrs_pkg::CMD_MEMBER)) begin
			rd_en   = 1'b1;
			rd_addr = value[WAW+PW-1:PW];
		end else if (state_q == ST_SCAN && !issue_done_q) begin
			rd_en = 1'b1;
		end
	end

	// Shared scan unit: mask the word to the range, count, accumulate.
	assign lo_w    = lo_q[WAW+PW-1:PW];
	assign hi_w    = hi_q[WAW+PW-1:PW];
	assign lo_mask = (proc_w_q == lo_w) ? ({WB{1'b1}} << lo_q[PW-1:0]) : {WB{1'b1}};
	assign hi_mask = (proc_w_q == hi_w) ?
		({WB{1'b1}} >> (PW'(WB - 1) - hi_q[PW-1:0])) : {WB{1'b1}};
	assign masked  = cur_word & lo_mask & hi_mask;
	assign pc      = bsrs_pkg::popcount32(masked);
	assign sum     = acc_q + CW'(pc);

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rdata_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			top_q        <= bsrs_pkg::TOP_RESET;
			cnt_q        <= '0;
			word_vld_q   <= '0;
			rvld_q       <= 1'b0;
			dvld_q       <= 1'b0;
			issue_done_q <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				top_q <= cfg_data;
			end
			if (rd_en) begin
				rvld_q <= word_vld_q[rd_addr];
			end
			if (wr_en) begin
				word_vld_q[wr_addr] <= 1'b1;
			end
			if (state_q == ST_DONE && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end

			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						cmd_q        <= cmd_in;
						val_q        <= value;
						acc_q        <= '0;
						res_answer_q <= '0;
						res_true_q   <= 1'b0;
						res_oor_q    <= 1'b0;
						dvld_q       <= 1'b0;
						issue_done_q <= 1'b0;
						state_q      <= ST_DONE;
						unique case (cmd_in) inside
							bsrs_pkg::CMD_CLEAR: begin
								word_vld_q <= '0;
								cnt_q      <= '0;
							end
							bsrs_pkg::CMD_INSERT, bsrs_pkg::CMD_DELETE,
							bsrs_pkg::CMD_MEMBER: begin
								res_answer_q <= cnt_q;
								if (above) begin
									res_oor_q <= 1'b1;
								end else begin
									state_q <= ST_MODIFY;
								end
							end
							bsrs_pkg::CMD_RANK: begin
								lo_q      <= '0;
								hi_q      <= value[EW-1:0];
								issue_w_q <= '0;
								if (above) begin
									res_oor_q <= 1'b1;
								end else begin
									state_q <= ST_SCAN;
								end
							end
							bsrs_pkg::CMD_SELECT: begin
								lo_q      <= '0;
								hi_q      <= eff_top;
								issue_w_q <= '0;
								if (value != '0 && value <= cnt_q) begin
									state_q <= ST_SCAN;
								end
							end
							bsrs_pkg::CMD_RANGE: begin
								lo_q      <= value[EW-1:0];
								hi_q      <= rend_clip;
								issue_w_q <= value[WAW+PW-1:PW];
								if (value <= {1'b0, rend_clip}) begin
									state_q <= ST_SCAN;
								end
							end
							default: begin
								res_answer_q <= cnt_q;
							end
						endcase
					end
				end
				ST_MODIFY: begin
					cnt_q        <= cnt_mod;
					res_answer_q <= cnt_mod;
					res_true_q   <= (cmd_q == bsrs_pkg::CMD_MEMBER) && cur_bit;
					state_q      <= ST_DONE;
				end
				ST_SCAN: begin
					// Issue the next word while the previous one is counted.
					if (rd_en) begin
						issue_w_q    <= issue_w_q + WAW'(1);
						issue_done_q <= (issue_w_q == hi_w);
						proc_w_q     <= issue_w_q;
					end
					dvld_q <= rd_en;
					if (dvld_q) begin
						acc_q <= sum;
						if (cmd_q == bsrs_pkg::CMD_SELECT && sum >= val_q) begin
							need_q      <= (PW+1)'(val_q - acc_q);
							find_word_q <= masked;
							find_w_q    <= proc_w_q;
							find_pos_q  <= '0;
							state_q     <= ST_FIND;
						end else if (proc_w_q == hi_w) begin
							if (cmd_q != bsrs_pkg::CMD_SELECT) begin
								res_answer_q <= sum;
							end
							state_q <= ST_DONE;
						end
					end
				end
				ST_FIND: begin
					// Walk the hit word one bit per cycle down to the wanted member.
					if (find_word_q[0]) begin
						if (need_q == (PW+1)'(1)) begin
							res_answer_q <= CW'({find_w_q, find_pos_q});
							res_true_q   <= 1'b1;
							state_q      <= ST_DONE;
						end
						need_q <= need_q - (PW+1)'(1);
					end
					find_word_q <= find_word_q >> 1;
					find_pos_q  <= find_pos_q + PW'(1);
				end
				ST_DONE: begin
					if (out_free) begin
						answer_q    <= res_answer_q;
						is_true_q   <= res_true_q;
						oor_q       <= res_oor_q;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign out_valid    = out_valid_q;
	assign answer       = answer_q;
	assign is_true      = is_true_q;
	assign out_of_range = oor_q;

endmodule

// ----- rtl/core/bsrs_checker.sv -----
// Port-level checks for the bit-vector rank/select block, bound to its top level.
`timescale 1ns / 1ps

module bsrs_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [10:0] answer,
	input logic        is_true,
	input logic        out_of_range
);

	// Hold a stalled result.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(answer) && $stable(is_true) &&
		$stable(out_of_range))
		else $error("stalled result changed");

	// Go busy once an item is taken.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("ready stayed high after accept");

	a_flags_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(is_true && out_of_range))
		else $error("is_true and out_of_range both set");

	// The answer never exceeds the universe size of 1024.
	a_answer_bound: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> answer <= 11'd1024)
		else $error("answer above 1024");

endmodule

bind bitset_rank_select bsrs_checker u_bsrs_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_valid     (in_valid),
	.in_ready     (in_ready),
	.out_valid    (out_valid),
	.out_ready    (out_ready),
	.answer       (answer),
	.is_true      (is_true),
	.out_of_range (out_of_range)
);

// ----- bench/bitset_rank_select_tb.sv -----
// Self-checking bench for the rank/select block: corner-case table, then random traffic.
`timescale 1ns / 1ps

module bitset_rank_select_tb;

	localparam int CW = bsrs_pkg::COUNT_W;
	localparam int EW = bsrs_pkg::ELEM_W;
	localparam int LONG_HOLD = 300;
	localparam int SETTLE_CYCLES = 100;
	localparam int PHASES = 9;
	localparam int PHASE_ITEMS = 145;

	typedef struct packed {
		logic [CW-1:0] answer;
		logic          is_true;
		logic          oor;
	} reply_t;

	typedef struct packed {
		logic           is_cfg;
		bsrs_pkg::cmd_t c;
		logic [CW-1:0]  v;
		logic [EW-1:0]  re;
		logic           typed;
		reply_t         want;
	} dir_row_t;

	logic                        clk = 1'b0;
	logic                        arst_n;
	logic                        cfg_valid;
	logic                        cfg_ready;
	logic [EW-1:0]               cfg_data;
	logic                        in_valid;
	logic                        in_ready;
	logic [bsrs_pkg::CMD_W-1:0]  cmd;
	logic [CW-1:0]               value;
	logic [EW-1:0]               range_end;
	logic                        out_valid;
	logic                        out_ready;
	logic [CW-1:0]               answer;
	logic                        is_true;
	logic                        out_of_range;

	// Shadow copy of the set and its top register.
	logic [bsrs_pkg::TOP_MAX:0]  shadow_bits;
	logic [CW-1:0]               shadow_count;
	logic [EW-1:0]               shadow_top;

	reply_t             pending_replies [$];
	dir_row_t           dir_rows [$];
	logic [CW-1:0]      recent_elems [16];

	int errors = 0;
	int items_sent = 0;
	int replies_checked = 0;
	int tops_written = 0;
	int cmd_seen [8];
	int hold_asked = 0;
	int hold_granted = 0;
	bit no_gap = 1'b0;

	bitset_rank_select i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.cmd          (cmd),
		.value        (value),
		.range_end    (range_end),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.answer       (answer),
		.is_true      (is_true),
		.out_of_range (out_of_range)
	);

	always #5 clk = ~clk;

	function automatic int count_members(input int lo, input int hi);
		int n;
		n = 0;
		for (int e = lo; e <= hi; e++) begin
			if (shadow_bits[e])
				n++;
		end
		return n;
	endfunction

	// Work out the reply of one command and advance the shadow set.
	task automatic apply_set_cmd(input bsrs_pkg::cmd_t c, input logic [CW-1:0] v,
			input logic [EW-1:0] re, output reply_t r);
		logic [EW-1:0] last;
		int seen;
		r = '0;
		case (c) inside
			bsrs_pkg::CMD_CLEAR: begin
				shadow_bits = '0;
				shadow_count = '0;
			end
			bsrs_pkg::CMD_INSERT, bsrs_pkg::CMD_DELETE, bsrs_pkg::CMD_MEMBER: begin
				if (v > shadow_top) begin
					r.oor = 1'b1;
				end else if (c == bsrs_pkg::CMD_INSERT) begin
					if (!shadow_bits[v]) begin
						shadow_bits[v] = 1'b1;
						shadow_count++;
					end
				end else if (c == bsrs_pkg::CMD_DELETE) begin
					if (shadow_bits[v]) begin
						shadow_bits[v] = 1'b0;
						shadow_count--;
					end
				end else begin
					r.is_true = shadow_bits[v];
				end
				r.answer = shadow_count;
			end
			bsrs_pkg::CMD_RANK: begin
				if (v > shadow_top)
					r.oor = 1'b1;
				else
					r.answer = CW'(count_members(0, v));
			end
			bsrs_pkg::CMD_SELECT: begin
				// Scan only up to the top; a k-th member above it is not found.
				if (v != 0 && v <= shadow_count) begin
					seen = 0;
					for (int e = 0; e <= shadow_top && !r.is_true; e++) begin
						if (shadow_bits[e]) begin
							seen++;
							if (seen == v) begin
								r.answer = CW'(e);
								r.is_true = 1'b1;
							end
						end
					end
				end
			end
			bsrs_pkg::CMD_RANGE: begin
				last = (re > shadow_top) ? shadow_top : re;
				if (v <= last)
					r.answer = CW'(count_members(v, last));
			end
			default: begin
				r.answer = shadow_count;
			end
		endcase
	endtask

	task automatic send_item(input bsrs_pkg::cmd_t c, input logic [CW-1:0] v,
			input logic [EW-1:0] re, input bit typed, input reply_t typed_r);
		int gap;
		reply_t r;
		gap = no_gap ? 0 : $urandom_range(0, 18);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		cmd <= c;
		value <= v;
		range_end <= re;
		do @(posedge clk); while (!in_ready);
		apply_set_cmd(c, v, re, r);
		pending_replies.push_back(typed ? typed_r : r);
		cmd_seen[c]++;
		items_sent++;
	endtask

	// Drop valid and hold until every reply is back.
	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_replies.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_top(input logic [EW-1:0] t);
		drain();
		repeat (4) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= t;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		shadow_top = t;
		tops_written++;
	endtask

	function automatic logic [CW-1:0] pick_elem();
		logic [CW-1:0] e;
		int r;
		r = $urandom_range(0, 19);
		case (r) inside
			0: begin
				e = CW'($urandom_range(0, 2047));
			end
			1: begin
				e = shadow_top;
				e = e + 1'b1;
			end
			2: begin
				e = shadow_top;
			end
			3: begin
				e = '0;
			end
			[4:8]: begin
				e = recent_elems[$urandom_range(0, 15)];
			end
			default: begin
				e = CW'($urandom_range(0, shadow_top));
			end
		endcase
		return e;
	endfunction

	function automatic void add_row(input bit is_cfg, input bsrs_pkg::cmd_t c, input int v,
			input int re, input bit typed, input int a, input bit t, input bit o);
		dir_row_t row;
		row.is_cfg = is_cfg;
		row.c = c;
		row.v = CW'(v);
		row.re = EW'(re);
		row.typed = typed;
		row.want = {a[CW-1:0], t, o};
		dir_rows.push_back(row);
	endfunction

	// Reply sink: random stalls and stall-free stretches, a long hold-off per request, in-order check.
	initial begin : reply_sink
		int stall;
		reply_t want;
		out_ready <= 1'b0;
		do @(posedge clk); while (!arst_n);
		forever begin
			if (hold_asked != hold_granted) begin
				hold_granted = hold_asked;
				stall = LONG_HOLD;
			end else if ((replies_checked / 50) % 3 == 1) begin
				stall = 0;
			end else begin
				stall = $urandom_range(0, 18);
			end
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
			if (pending_replies.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("unexpected reply: answer=%0d is_true=%0b out_of_range=%0b",
						answer, is_true, out_of_range);
			end else begin
				want = pending_replies.pop_front();
				if (answer !== want.answer || is_true !== want.is_true
						|| out_of_range !== want.oor) begin
					errors++;
					if (errors <= 10)
						$display("reply %0d: expected %0d/%0b/%0b, got %0d/%0b/%0b",
							replies_checked, want.answer, want.is_true, want.oor,
							answer, is_true, out_of_range);
				end
			end
			replies_checked++;
		end
	end

	initial begin : stimulus
		int r;
		int s;
		int tmp;
		int phase_top [PHASES];
		bsrs_pkg::cmd_t c;
		logic [CW-1:0] v;
		logic [EW-1:0] re;
		dir_row_t row;

		arst_n <= 1'b0;
		cfg_valid <= 1'b0;
		cfg_data <= '0;
		in_valid <= 1'b0;
		cmd <= bsrs_pkg::CMD_NONE;
		value <= '0;
		range_end <= '0;
		shadow_bits = '0;
		shadow_count = '0;
		shadow_top = bsrs_pkg::TOP_RESET;
		for (int i = 0; i < 16; i++)
			recent_elems[i] = '0;
		for (int i = 0; i < 8; i++)
			cmd_seen[i] = 0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Corner cases under the reset top, then with the top lowered.
		add_row(0, bsrs_pkg::CMD_NONE,   0,    0,    1, 0,    0, 0);
		add_row(0, bsrs_pkg::CMD_MEMBER, 5,    0,    1, 0,    0, 0);
		add_row(0, bsrs_pkg::CMD_SELECT, 0,    0,    1, 0,    0, 0);
		add_row(0, bsrs_pkg::CMD_SELECT, 1,    0,    1, 0,    0, 0);
		add_row(0, bsrs_pkg::CMD_INSERT, 0,    0,    1, 1,    0, 0);
		add_row(0, bsrs_pkg::CMD_INSERT, 1023, 0,    1, 2,    0, 0);
		add_row(0, bsrs_pkg::CMD_INSERT, 1023, 0,    1, 2,    0, 0);
		add_row(0, bsrs_pkg::CMD_INSERT, 2047, 1023, 1, 2,    0, 1);
		add_row(0, bsrs_pkg::CMD_MEMBER, 1023, 0,    1, 2,    1, 0);
		add_row(0, bsrs_pkg::CMD_MEMBER, 1024, 0,    1, 2,    0, 1);
		add_row(0, bsrs_pkg::CMD_RANK,   1024, 0,    1, 0,    0, 1);
		add_row(0, bsrs_pkg::CMD_RANK,   0,    0,    0, 0,    0, 0);
		add_row(0, bsrs_pkg::CMD_RANK,   1023, 0,    0, 0,    0, 0);
		add_row(0, bsrs_pkg::CMD_SELECT, 2,    0,    0, 0,    0, 0);
		add_row(0, bsrs_pkg::CMD_SELECT, 3,    0,    1, 0,    0, 0);
		add_row(0, bsrs_pkg::CMD_RANGE,  0,    1023, 0, 0,    0, 0);
		add_row(0, bsrs_pkg::CMD_RANGE,  1024, 1023, 1, 0,    0, 0);
		add_row(0, bsrs_pkg::CMD_RANGE,  600,  599,  1, 0,    0, 0);
		add_row(0, bsrs_pkg::CMD_DELETE, 5,    0,    0, 0,    0, 0);
		add_row(0, bsrs_pkg::CMD_INSERT, 700,  0,    0, 0,    0, 0);
		add_row(1, bsrs_pkg::CMD_NONE,   500,  0,    0, 0,    0, 0);
		add_row(0, bsrs_pkg::CMD_SELECT, 3,    0,    1, 0,    0, 0);
		add_row(0, bsrs_pkg::CMD_RANGE,  1,    1023, 0, 0,    0, 0);
		add_row(0, bsrs_pkg::CMD_DELETE, 700,  0,    1, 3,    0, 1);
		add_row(0, bsrs_pkg::CMD_CLEAR,  0,    0,    1, 0,    0, 0);
		add_row(1, bsrs_pkg::CMD_NONE,   0,    0,    0, 0,    0, 0);
		add_row(0, bsrs_pkg::CMD_INSERT, 0,    0,    0, 0,    0, 0);
		add_row(0, bsrs_pkg::CMD_RANK,   0,    0,    0, 0,    0, 0);
		add_row(0, bsrs_pkg::CMD_NONE,   2047, 1023, 0, 0,    0, 0);

		foreach (dir_rows[n]) begin
			row = dir_rows[n];
			if (row.is_cfg)
				write_top(row.v[EW-1:0]);
			else
				send_item(row.c, row.v, row.re, row.typed, row.want);
		end

		phase_top = '{1023, 0, 7, 32, 31, 511, 0, 1000, 1023};
		phase_top[6] = $urandom_range(0, bsrs_pkg::TOP_MAX);

		for (int p = 0; p < PHASES; p++) begin
			write_top(EW'(phase_top[p]));
			for (int i = 0; i < PHASE_ITEMS; i++) begin
				no_gap = ((i / 30) % 4 == 0);
				if (i == 70 && (p == 1 || p == 5))
					hold_asked++;
				if (i == 70 && p == 3)
					drain();
				r = $urandom_range(0, 99);
				v = pick_elem();
				re = EW'($urandom_range(0, bsrs_pkg::TOP_MAX));
				if (r < 1) begin
					c = bsrs_pkg::CMD_CLEAR;
				end else if (r < 3) begin
					c = bsrs_pkg::CMD_NONE;
				end else if (r < 33) begin
					c = bsrs_pkg::CMD_INSERT;
					recent_elems[$urandom_range(0, 15)] = v;
				end else if (r < 45) begin
					c = bsrs_pkg::CMD_DELETE;
				end else if (r < 57) begin
					c = bsrs_pkg::CMD_MEMBER;
				end else if (r < 71) begin
					c = bsrs_pkg::CMD_RANK;
				end else if (r < 87) begin
					c = bsrs_pkg::CMD_SELECT;
					s = $urandom_range(0, 9);
					if (s == 0)
						v = '0;
					else if (s == 1)
						v = shadow_count + 1'b1;
					else if (s == 2)
						v = shadow_count;
					else
						v = CW'($urandom_range(1, (shadow_count == 0) ? 1 : shadow_count));
				end else begin
					c = bsrs_pkg::CMD_RANGE;
					// Keep some ranges short and anchored at the start.
					if ($urandom_range(0, 1)) begin
						tmp = v + $urandom_range(0, 40);
						re = EW'(tmp);
					end
				end
				send_item(c, v, re, 1'b0, '0);
			end
		end

		drain();
		repeat (SETTLE_CYCLES) @(posedge clk);

		$display("%0d commands over %0d top settings, %0d replies checked",
			items_sent, tops_written, replies_checked);
		$display("mix: clear %0d ins %0d del %0d mem %0d rank %0d sel %0d range %0d none %0d",
			cmd_seen[bsrs_pkg::CMD_CLEAR], cmd_seen[bsrs_pkg::CMD_INSERT],
			cmd_seen[bsrs_pkg::CMD_DELETE], cmd_seen[bsrs_pkg::CMD_MEMBER],
			cmd_seen[bsrs_pkg::CMD_RANK], cmd_seen[bsrs_pkg::CMD_SELECT],
			cmd_seen[bsrs_pkg::CMD_RANGE], cmd_seen[bsrs_pkg::CMD_NONE]);
		if (errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

	initial begin : watchdog
		#6_000_000;
		$display("timeout: block stopped responding");
		$display("DONE: errors detected");
		$finish;
	end

endmodule
